// ----- sv/rke_pkg.sv -----
// Shared constants, types and lookup functions of the AES-128 round key expander.
// No dependencies; every other file of the block imports this package.
package rke_pkg;

    localparam int          WORD_W     = 32;
    localparam int          KEY_WORDS  = 4;
    localparam int          HALF_W     = 64;
    localparam int          ROUND_W    = 4;
    localparam int          ROUND_KEYS = 11;
    localparam logic [ROUND_W-1:0] LAST_ROUND = ROUND_W'(ROUND_KEYS - 1);

    typedef logic [WORD_W-1:0] word_t;

    // Control that the sequencer hands to every word cell.
    typedef struct packed {
        logic load;  // take a new key word
        logic step;  // move on to the next round key
    } cell_ctrl_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63, 8'h7C, 8'h77, 8'h7B, 8'hF2, 8'h6B, 8'h6F, 8'hC5,
        8'h30, 8'h01, 8'h67, 8'h2B, 8'hFE, 8'hD7, 8'hAB, 8'h76,
        8'hCA, 8'h82, 8'hC9, 8'h7D, 8'hFA, 8'h59, 8'h47, 8'hF0,
        8'hAD, 8'hD4, 8'hA2, 8'hAF, 8'h9C, 8'hA4, 8'h72, 8'hC0,
        8'hB7, 8'hFD, 8'h93, 8'h26, 8'h36, 8'h3F, 8'hF7, 8'hCC,
        8'h34, 8'hA5, 8'hE5, 8'hF1, 8'h71, 8'hD8, 8'h31, 8'h15,
        8'h04, 8'hC7, 8'h23, 8'hC3, 8'h18, 8'h96, 8'h05, 8'h9A,
        8'h07, 8'h12, 8'h80, 8'hE2, 8'hEB, 8'h27, 8'hB2, 8'h75,
        8'h09, 8'h83, 8'h2C, 8'h1A, 8'h1B, 8'h6E, 8'h5A, 8'hA0,
        8'h52, 8'h3B, 8'hD6, 8'hB3, 8'h29, 8'hE3, 8'h2F, 8'h84,
        8'h53, 8'hD1, 8'h00, 8'hED, 8'h20, 8'hFC, 8'hB1, 8'h5B,
        8'h6A, 8'hCB, 8'hBE, 8'h39, 8'h4A, 8'h4C, 8'h58, 8'hCF,
        8'hD0, 8'hEF, 8'hAA, 8'hFB, 8'h43, 8'h4D, 8'h33, 8'h85,
        8'h45, 8'hF9, 8'h02, 8'h7F, 8'h50, 8'h3C, 8'h9F, 8'hA8,
        8'h51, 8'hA3, 8'h40, 8'h8F, 8'h92, 8'h9D, 8'h38, 8'hF5,
        8'hBC, 8'hB6, 8'hDA, 8'h21, 8'h10, 8'hFF, 8'hF3, 8'hD2,
        8'hCD, 8'h0C, 8'h13, 8'hEC, 8'h5F, 8'h97, 8'h44, 8'h17,
        8'hC4, 8'hA7, 8'h7E, 8'h3D, 8'h64, 8'h5D, 8'h19, 8'h73,
        8'h60, 8'h81, 8'h4F, 8'hDC, 8'h22, 8'h2A, 8'h90, 8'h88,
        8'h46, 8'hEE, 8'hB8, 8'h14, 8'hDE, 8'h5E, 8'h0B, 8'hDB,
        8'hE0, 8'h32, 8'h3A, 8'h0A, 8'h49, 8'h06, 8'h24, 8'h5C,
        8'hC2, 8'hD3, 8'hAC, 8'h62, 8'h91, 8'h95, 8'hE4, 8'h79,
        8'hE7, 8'hC8, 8'h37, 8'h6D, 8'h8D, 8'hD5, 8'h4E, 8'hA9,
        8'h6C, 8'h56, 8'hF4, 8'hEA, 8'h65, 8'h7A, 8'hAE, 8'h08,
        8'hBA, 8'h78, 8'h25, 8'h2E, 8'h1C, 8'hA6, 8'hB4, 8'hC6,
        8'hE8, 8'hDD, 8'h74, 8'h1F, 8'h4B, 8'hBD, 8'h8B, 8'h8A,
        8'h70, 8'h3E, 8'hB5, 8'h66, 8'h48, 8'h03, 8'hF6, 8'h0E,
        8'h61, 8'h35, 8'h57, 8'hB9, 8'h86, 8'hC1, 8'h1D, 8'h9E,
        8'hE1, 8'hF8, 8'h98, 8'h11, 8'h69, 8'hD9, 8'h8E, 8'h94,
        8'h9B, 8'h1E, 8'h87, 8'hE9, 8'hCE, 8'h55, 8'h28, 8'hDF,
        8'h8C, 8'hA1, 8'h89, 8'h0D, 8'hBF, 8'hE6, 8'h42, 8'h68,
        8'h41, 8'h99, 8'h2D, 8'h0F, 8'hB0, 8'h54, 8'hBB, 8'h16
    };

    // Round constant for rounds 1 to 10; round 0 never uses one.
    function automatic logic [7:0] rcon(input logic [ROUND_W-1:0] round);
        logic [7:0] value;
        case (round)
            4'd1:    value = 8'h01;
            4'd2:    value = 8'h02;
            4'd3:    value = 8'h04;
            4'd4:    value = 8'h08;
            4'd5:    value = 8'h10;
            4'd6:    value = 8'h20;
            4'd7:    value = 8'h40;
            4'd8:    value = 8'h80;
            4'd9:    value = 8'h1B;
            4'd10:   value = 8'h36;
            default: value = 8'h8D;
        endcase
        return value;
    endfunction

endpackage

// ----- sv/round_key_expander.sv -----
// Top level of the AES-128 round key expander: sequencer, cell row and output register.
// Depends on rke_pkg, rke_sched_cell and rke_word_cell.
//
//  channel | direction | handshake                 | payload
//  key     | in        | key_valid / key_stall     | key_high, key_low
//  round   | out       | round_valid / round_stall | round_number, round_key_high,
//          |           |                           | round_key_low, is_last
//
// The cell row makes one round key per cycle while the round channel does not stall,
// set by the single schedule cell feeding the four word cells; 11 round keys leave per key.
// The next key is taken in the cycle that round 10 moves to the output register.
// A stall on the round channel holds the output register and freezes the cell row.
// Reset clears the busy flag and the output valid; no clearing pass is needed.
module round_key_expander
    import rke_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  key_valid,
    output logic                  key_stall,
    input  logic [HALF_W-1:0]     key_high,
    input  logic [HALF_W-1:0]     key_low,
    output logic                  round_valid,
    input  logic                  round_stall,
    output logic [ROUND_W-1:0]    round_number,
    output logic [HALF_W-1:0]     round_key_high,
    output logic [HALF_W-1:0]     round_key_low,
    output logic                  is_last
);

    logic               busy_reg;
    logic               busy_next;
    logic [ROUND_W-1:0] round_reg;
    logic [ROUND_W-1:0] round_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [ROUND_W-1:0] out_round_reg;
    logic [HALF_W-1:0]  out_high_reg;
    logic [HALF_W-1:0]  out_low_reg;
    logic               out_last_reg;

    logic       out_free;
    logic       advance;
    logic       at_last;
    logic       key_accept;
    cell_ctrl_t ctrl;

    word_t key_words [KEY_WORDS];
    word_t words     [KEY_WORDS];
    word_t chain     [KEY_WORDS+1];

    assign out_free   = !out_valid_reg || !round_stall;
    assign advance    = busy_reg && out_free;
    assign at_last    = (round_reg == LAST_ROUND);
    assign key_stall  = busy_reg && !(advance && at_last);
    assign key_accept = key_valid && !key_stall;

    assign ctrl.load = key_accept;
    assign ctrl.step = advance && !at_last;

    assign key_words[0] = key_high[63:32];
    assign key_words[1] = key_high[31:0];
    assign key_words[2] = key_low[63:32];
    assign key_words[3] = key_low[31:0];

    rke_sched_cell u_sched (
        .last_word  (words[KEY_WORDS-1]),
        .next_round (round_reg + ROUND_W'(1)),
        .mix_word   (chain[0])
    );

    for (genvar i = 0; i < KEY_WORDS; i++)
    begin : g_cell
        rke_word_cell u_word (
            .clk       (clk),
            .ctrl      (ctrl),
            .key_word  (key_words[i]),
            .chain_in  (chain[i]),
            .chain_out (chain[i+1]),
            .word      (words[i])
        );
    end

    always_comb
    begin
        busy_next      = busy_reg;
        round_next     = round_reg;
        out_valid_next = out_valid_reg;
        if (out_free)
        begin
            out_valid_next = advance;
        end
        if (key_accept)
        begin
            busy_next  = 1'b1;
            round_next = '0;
        end
        else if (advance)
        begin
            if (at_last)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                round_next = round_reg + ROUND_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            round_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            round_reg     <= round_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_round_reg <= round_reg;
            out_high_reg  <= {words[0], words[1]};
            out_low_reg   <= {words[2], words[3]};
            out_last_reg  <= at_last;
        end
    end

    assign round_valid    = out_valid_reg;
    assign round_number   = out_round_reg;
    assign round_key_high = out_high_reg;
    assign round_key_low  = out_low_reg;
    assign is_last        = out_last_reg;

endmodule

// ----- sv/rke_sched_cell.sv -----
// Schedule cell: RotWord, SubWord and round constant applied to the last key word.
// Depends on rke_pkg for the S-box and round constant tables.
module rke_sched_cell
    import rke_pkg::*;
(
    input  word_t              last_word,
    input  logic [ROUND_W-1:0] next_round,
    output word_t              mix_word
);

    word_t rotated;
    word_t subbed;

    assign rotated = {last_word[23:0], last_word[31:24]};

    always_comb
    begin
        for (int b = 0; b < 4; b++)
        begin
            subbed[b*8 +: 8] = SBOX[rotated[b*8 +: 8]];
        end
    end

    assign mix_word = subbed ^ {rcon(next_round), 24'h000000};

endmodule

// ----- sv/rke_word_cell.sv -----
// Word cell: holds one 32-bit word of the current round key.
// Depends on rke_pkg for the word and control types.
module rke_word_cell
    import rke_pkg::*;
(
    input  logic       clk,
    input  cell_ctrl_t ctrl,
    input  word_t      key_word,
    input  word_t      chain_in,
    output word_t      chain_out,
    output word_t      word
);

    word_t word_reg;
    word_t word_next;

    // The new word is the old one XORed with the new word of the left neighbor.
    assign chain_out = word_reg ^ chain_in;

    always_comb
    begin
        if (ctrl.load)
        begin
            word_next = key_word;
        end
        else if (ctrl.step)
        begin
            word_next = chain_out;
        end
        else
        begin
            word_next = word_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign word = word_reg;

endmodule

// ----- sv/rke_checker.sv -----
// Port-level checks of the round key expander, bound to the top level.
// Depends on rke_pkg and on the ports of round_key_expander.
module rke_checker
    import rke_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               key_valid,
    input logic               key_stall,
    input logic               round_valid,
    input logic               round_stall,
    input logic [ROUND_W-1:0] round_number,
    input logic               is_last
);

    // A held result keeps its round number.
    assert property (@(posedge clk) disable iff (!rst_n)
        round_valid && round_stall |=> round_valid && $stable(round_number))
    else $error("stalled round transaction changed");

    assert property (@(posedge clk) disable iff (!rst_n)
        round_valid |-> (is_last == (round_number == LAST_ROUND)))
    else $error("last flag does not match round ten");

    assert property (@(posedge clk) disable iff (!rst_n)
        round_valid |-> (round_number <= LAST_ROUND))
    else $error("round number out of range");

    // Once a key is taken the block is busy with it.
    assert property (@(posedge clk) disable iff (!rst_n)
        key_valid && !key_stall |=> key_stall)
    else $error("second key taken right after a key");

    // Round keys of one key follow one another without a gap.
    assert property (@(posedge clk) disable iff (!rst_n)
        round_valid && !round_stall && (round_number != LAST_ROUND)
        |=> round_valid && (round_number == $past(round_number) + ROUND_W'(1)))
    else $error("round keys out of sequence");

endmodule

bind round_key_expander rke_checker u_rke_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .key_valid    (key_valid),
    .key_stall    (key_stall),
    .round_valid  (round_valid),
    .round_stall  (round_stall),
    .round_number (round_number),
    .is_last      (is_last)
);

// ----- tb/tb_round_key_expander.sv -----
// Self-checking testbench for round_key_expander: drives cipher keys and checks all eleven
// round keys of each against an AES-128 key schedule computed here from GF(2^8) arithmetic.
// Depends on rke_pkg and round_key_expander.
module tb_round_key_expander;
    import rke_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int RANDOM_KEYS  = 360;
    localparam int LONG_HOLD    = 400;
    localparam int HOLD_AT_1    = 1500;
    localparam int HOLD_AT_2    = 6000;
    localparam int TAIL_CYCLES  = 40;
    localparam int REPORT_LIMIT = 10;

    typedef struct {
        logic [HALF_W-1:0] high;
        logic [HALF_W-1:0] low;
        bit                drain_first;  // wait until every round key so far has left
    } key_item_t;

    typedef struct {
        logic [ROUND_W-1:0] number;
        logic [HALF_W-1:0]  high;
        logic [HALF_W-1:0]  low;
        logic               last;
    } round_key_t;

    logic                clk;
    logic                rst_n;
    logic                key_valid;
    logic                key_stall;
    logic [HALF_W-1:0]   key_high;
    logic [HALF_W-1:0]   key_low;
    logic                round_valid;
    logic                round_stall;
    logic [ROUND_W-1:0]  round_number;
    logic [HALF_W-1:0]   round_key_high;
    logic [HALF_W-1:0]   round_key_low;
    logic                is_last;

    key_item_t  keys_to_send[$];
    round_key_t rounds_due[$];
    logic [7:0] sbox_lut [256];
    int         errors;
    int         keys_offered;
    int         keys_taken;
    int         keys_total;
    int         gap_left;
    int         cycle_cnt;

    round_key_expander u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .key_valid      (key_valid),
        .key_stall      (key_stall),
        .key_high       (key_high),
        .key_low        (key_low),
        .round_valid    (round_valid),
        .round_stall    (round_stall),
        .round_number   (round_number),
        .round_key_high (round_key_high),
        .round_key_low  (round_key_low),
        .is_last        (is_last)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] p;
        logic       carry;
        p = 8'h00;
        for (int i = 0; i < 8; i++)
        begin
            if (b[0])
                p = p ^ a;
            carry = a[7];
            a = {a[6:0], 1'b0};
            if (carry)
                a = a ^ 8'h1b;
            b = b >> 1;
        end
        return p;
    endfunction

    // Most gaps are short, a few long; calm stretches have none at all.
    function automatic int pick_gap(input bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 50)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    task automatic add_key(input logic [HALF_W-1:0] high, input logic [HALF_W-1:0] low,
                           input bit drain_first);
        key_item_t item;
        item.high        = high;
        item.low         = low;
        item.drain_first = drain_first;
        keys_to_send.push_back(item);
    endtask

    // AES-128 key schedule: queues round keys 0 to 10 for one accepted key.
    task automatic expand_key(input logic [HALF_W-1:0] high, input logic [HALF_W-1:0] low);
        word_t      w [4];
        word_t      t;
        logic [7:0] rc;
        round_key_t rk;
        w[0] = high[63:32];
        w[1] = high[31:0];
        w[2] = low[63:32];
        w[3] = low[31:0];
        rc = 8'h01;
        for (int r = 0; r < ROUND_KEYS; r++)
        begin
            if (r > 0)
            begin
                t = {w[3][23:0], w[3][31:24]};
                t = {sbox_lut[t[31:24]], sbox_lut[t[23:16]],
                     sbox_lut[t[15:8]], sbox_lut[t[7:0]]} ^ {rc, 24'h000000};
                rc = gf_mul(rc, 8'h02);
                w[0] = w[0] ^ t;
                w[1] = w[1] ^ w[0];
                w[2] = w[2] ^ w[1];
                w[3] = w[3] ^ w[2];
            end
            rk.number = ROUND_W'(r);
            rk.high   = {w[0], w[1]};
            rk.low    = {w[2], w[3]};
            rk.last   = (r == ROUND_KEYS - 1);
            rounds_due.push_back(rk);
        end
    endtask

    // Key driver: offers queued keys and predicts the round keys of each accepted one.
    always @(posedge clk)
    begin : key_driver
        key_item_t next_item;
        logic      offer;
        if (!rst_n)
        begin
            key_valid <= 1'b0;
        end
        else
        begin
            offer = key_valid;
            if (key_valid && !key_stall)
            begin
                expand_key(key_high, key_low);
                keys_taken++;
                offer = 1'b0;
            end
            if (!offer)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                end
                else if (keys_to_send.size() > 0 &&
                         !(keys_to_send[0].drain_first && rounds_due.size() != 0))
                begin
                    next_item = keys_to_send.pop_front();
                    key_high <= next_item.high;
                    key_low  <= next_item.low;
                    offer = 1'b1;
                    keys_offered++;
                    gap_left = pick_gap((keys_offered % 48) < 12);
                end
            end
            key_valid <= offer;
        end
    end

    // Round key receiver: random stalls plus two long hold-offs that back up the key side.
    always @(posedge clk)
    begin : round_receiver
        int rx_cycles;
        int hold_left;
        int stall_left;
        if (!rst_n)
        begin
            round_stall <= 1'b0;
            rx_cycles  = 0;
            hold_left  = 0;
            stall_left = 0;
        end
        else
        begin
            rx_cycles++;
            if (rx_cycles == HOLD_AT_1 || rx_cycles == HOLD_AT_2)
                hold_left = LONG_HOLD;
            if (hold_left > 0)
            begin
                hold_left--;
                round_stall <= 1'b1;
            end
            else
            begin
                if (stall_left == 0 && (rx_cycles % 1200) >= 300 && $urandom_range(0, 2) == 0)
                    stall_left = pick_gap(1'b0);
                round_stall <= (stall_left != 0);
                if (stall_left != 0)
                    stall_left--;
            end
        end
    end

    // Checks every round key transaction against the oldest prediction.
    always @(posedge clk)
    begin : round_monitor
        round_key_t want;
        if (rst_n && round_valid && !round_stall)
        begin
            if (rounds_due.size() == 0)
            begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("unexpected round key transaction: round %0d key %h_%h last %b",
                             round_number, round_key_high, round_key_low, is_last);
            end
            else
            begin
                want = rounds_due.pop_front();
                if (round_number !== want.number || round_key_high !== want.high ||
                    round_key_low !== want.low || is_last !== want.last)
                begin
                    errors++;
                    if (errors <= REPORT_LIMIT)
                        $display("round key mismatch: exp %0d %h_%h %b, got %0d %h_%h %b",
                                 want.number, want.high, want.low, want.last,
                                 round_number, round_key_high, round_key_low, is_last);
                end
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("tb_round_key_expander: done, errors");
            $finish;
        end
    end

    initial
    begin : main
        logic [7:0]        inv;
        logic [HALF_W-1:0] hi;
        logic [HALF_W-1:0] lo;
        logic [7:0]        fill;
        int                pick;

        rst_n        = 1'b0;
        key_valid    = 1'b0;
        key_high     = '0;
        key_low      = '0;
        round_stall  = 1'b0;
        errors       = 0;
        keys_offered = 0;
        keys_taken   = 0;
        keys_total   = 0;
        gap_left     = 0;
        cycle_cnt    = 0;

        // S-box: multiplicative inverse in GF(2^8), then the affine map.
        for (int a = 0; a < 256; a++)
        begin
            inv = 8'h01;
            for (int i = 0; i < 254; i++)
                inv = gf_mul(inv, 8'(a));
            sbox_lut[a] = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^
                          {inv[4:0], inv[7:5]} ^ {inv[3:0], inv[7:4]} ^ 8'h63;
        end

        // Directed keys: extremes, standard test keys and single-bit patterns.
        add_key(64'h0000000000000000, 64'h0000000000000000, 1'b0);
        add_key(64'hffffffffffffffff, 64'hffffffffffffffff, 1'b0);
        add_key(64'h2b7e151628aed2a6, 64'habf7158809cf4f3c, 1'b0);
        add_key(64'h0001020304050607, 64'h08090a0b0c0d0e0f, 1'b0);
        add_key(64'h5555555555555555, 64'haaaaaaaaaaaaaaaa, 1'b0);
        add_key(64'haaaaaaaaaaaaaaaa, 64'h5555555555555555, 1'b0);
        add_key(64'hffffffffffffffff, 64'h0000000000000000, 1'b0);
        add_key(64'h0000000000000000, 64'hffffffffffffffff, 1'b0);
        add_key(64'h8000000000000000, 64'h0000000000000000, 1'b0);
        add_key(64'h0000000000000000, 64'h0000000000000001, 1'b0);
        add_key(64'h0000000000000001, 64'h8000000000000000, 1'b0);
        add_key(64'h0000000000000000, 64'h00000000ffffffff, 1'b0);
        add_key(64'hfedcba9876543210, 64'h0123456789abcdef, 1'b0);
        add_key(64'h0f0f0f0f0f0f0f0f, 64'hf0f0f0f0f0f0f0f0, 1'b0);

        for (int n = 0; n < RANDOM_KEYS; n++)
        begin
            pick = $urandom_range(0, 15);
            if (pick == 0)
            begin
                hi = '0;
                lo = '0;
                hi[$urandom_range(0, 63)] = 1'b1;
                lo[$urandom_range(0, 63)] = 1'b1;
            end
            else if (pick < 3)
            begin
                fill = 8'($urandom);
                hi = {8{fill}};
                lo = {8{fill}};
            end
            else
            begin
                hi = {$urandom, $urandom};
                lo = {$urandom, $urandom};
            end
            add_key(hi, lo, n == 0 || $urandom_range(0, 59) == 0);
        end
        keys_total = keys_to_send.size();

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // The accept count and the predictions move together in the driver.
        do
            @(posedge clk);
        while (keys_taken != keys_total || rounds_due.size() != 0);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (errors == 0 && rounds_due.size() == 0)
            $display("tb_round_key_expander: done, clean");
        else
            $display("tb_round_key_expander: done, errors");
        $finish;
    end

endmodule
